// ----- rtl/core/tcfifo_pkg.sv -----
// ----------------------------------------------------------------------------
// tcfifo_pkg
// shared types and constants of the two-class oldest-first queue unit
// ----------------------------------------------------------------------------
package tcfifo_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int ID_W        = 16;
  localparam int STAMP_W     = 32;
  localparam int ENTRY_W     = ID_W + STAMP_W;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 56;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ0 = 2'd1,
    OP_DEQ1 = 2'd2,
    OP_ANY  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

// ----- rtl/core/tcfifo_ram.sv -----
// ----------------------------------------------------------------------------
// tcfifo_ram
// simple dual-port ram, one write port and one read port with registered data
// ----------------------------------------------------------------------------
module tcfifo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/two_class_fifo_oldest_first_unit.sv -----
// ----------------------------------------------------------------------------
// two_class_fifo_oldest_first_unit
// enqueue: status registered on acceptance; dequeue: head read from the class ram, then
// decided in S_READ; throughput: one enqueue per cycle, no new request during a dequeue
// a new request is taken only in S_IDLE while the output register is empty or being drained
// reset: synchronous active-low rst_n clears heads, counts, stamp counter and output
// valid; ram contents are left as they are
// ----------------------------------------------------------------------------
module two_class_fifo_oldest_first_unit #(
  parameter int QUEUE_DEPTH = tcfifo_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // op[1:0], item_id[17:2], zero fill
  input  logic [tcfifo_pkg::IN_TDATA_W-1:0]  in_tdata,
  // item_class[0]
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // status[1:0], out_entry[2], out_id[18:3], out_stamp[50:19], zero fill
  output logic [tcfifo_pkg::OUT_TDATA_W-1:0] out_tdata,
  // out_class[0]
  output logic                               out_tuser
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W  = tcfifo_pkg::ID_W;
  localparam int SW    = tcfifo_pkg::STAMP_W;
  localparam int EW    = tcfifo_pkg::ENTRY_W;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_C  = IDX_W'(QUEUE_DEPTH - 1);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t                state_r, state_nxt;
  tcfifo_pkg::op_t       op_r, op_nxt;
  logic [IDX_W-1:0]      head0_r, head0_nxt, head1_r, head1_nxt;
  logic [CNT_W-1:0]      cnt0_r, cnt0_nxt, cnt1_r, cnt1_nxt;
  logic [SW-1:0]         stamp_r, stamp_nxt;

  logic                  out_vld_r, out_vld_nxt;
  tcfifo_pkg::status_t   out_status_r, out_status_nxt;
  logic                  out_ent_r, out_ent_nxt;
  logic                  out_cls_r, out_cls_nxt;
  logic [ID_W-1:0]       out_id_r, out_id_nxt;
  logic [SW-1:0]         out_stamp_r, out_stamp_nxt;

  logic                  accept, out_free;
  tcfifo_pkg::op_t       in_op;
  logic [ID_W-1:0]       in_id;

  logic                  we0, we1, re;
  logic [IDX_W-1:0]      tail0, tail1;
  logic [EW-1:0]         wdata, rdata0, rdata1;
  logic [SW-1:0]         diff;
  logic                  take0, take1;

  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, off};
    if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] idx);
    return (idx == LAST_C) ? '0 : idx + IDX_W'(1);
  endfunction

  assign in_op    = tcfifo_pkg::op_t'(in_tdata[1:0]);
  assign in_id    = in_tdata[ID_W+1:2];
  assign out_free = !out_vld_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign accept   = in_tvalid && in_tready;

  assign tail0 = ring_add(head0_r, cnt0_r);
  assign tail1 = ring_add(head1_r, cnt1_r);
  assign wdata = {stamp_r, in_id};
  assign we0   = accept && (in_op == tcfifo_pkg::OP_ENQ) && !in_tuser && (cnt0_r != DEPTH_C);
  assign we1   = accept && (in_op == tcfifo_pkg::OP_ENQ) && in_tuser && (cnt1_r != DEPTH_C);
  assign re    = accept && (in_op != tcfifo_pkg::OP_ENQ);

  tcfifo_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_ram0 (
    .clk   (clk),
    .we    (we0),
    .waddr (tail0),
    .wdata (wdata),
    .re    (re),
    .raddr (head0_r),
    .rdata (rdata0)
  );

  tcfifo_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_ram1 (
    .clk   (clk),
    .we    (we1),
    .waddr (tail1),
    .wdata (wdata),
    .re    (re),
    .raddr (head1_r),
    .rdata (rdata1)
  );

  // head stamp difference, class 0 minus class 1, modulo 2^32
  assign diff = rdata0[EW-1:ID_W] - rdata1[EW-1:ID_W];

  always_comb begin
    take0 = 1'b0;
    take1 = 1'b0;
    case (op_r)
      tcfifo_pkg::OP_DEQ0: begin
        take0 = (cnt0_r != '0);
      end
      tcfifo_pkg::OP_DEQ1: begin
        take1 = (cnt1_r != '0);
      end
      default: begin
        if (cnt0_r == '0) begin
          take1 = (cnt1_r != '0);
        end else if (cnt1_r == '0) begin
          take0 = 1'b1;
        end else begin
          take0 = diff[SW-1];
          take1 = !diff[SW-1];
        end
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    head0_nxt      = head0_r;
    head1_nxt      = head1_r;
    cnt0_nxt       = cnt0_r;
    cnt1_nxt       = cnt1_r;
    stamp_nxt      = stamp_r;
    out_vld_nxt    = out_vld_r && !out_tready;
    out_status_nxt = out_status_r;
    out_ent_nxt    = out_ent_r;
    out_cls_nxt    = out_cls_r;
    out_id_nxt     = out_id_r;
    out_stamp_nxt  = out_stamp_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op == tcfifo_pkg::OP_ENQ) begin
            out_vld_nxt   = 1'b1;
            out_ent_nxt   = 1'b0;
            out_cls_nxt   = 1'b0;
            out_id_nxt    = '0;
            out_stamp_nxt = '0;
            if (we0 || we1) begin
              out_status_nxt = tcfifo_pkg::ST_OK;
              stamp_nxt      = stamp_r + SW'(1);
            end else begin
              out_status_nxt = tcfifo_pkg::ST_FULL;
            end
            if (we0) begin
              cnt0_nxt = cnt0_r + CNT_W'(1);
            end
            if (we1) begin
              cnt1_nxt = cnt1_r + CNT_W'(1);
            end
          end else begin
            op_nxt    = in_op;
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          state_nxt   = S_IDLE;
          if (take0) begin
            out_status_nxt = tcfifo_pkg::ST_OK;
            out_ent_nxt    = 1'b1;
            out_cls_nxt    = 1'b0;
            out_id_nxt     = rdata0[ID_W-1:0];
            out_stamp_nxt  = rdata0[EW-1:ID_W];
            head0_nxt      = ring_inc(head0_r);
            cnt0_nxt       = cnt0_r - CNT_W'(1);
          end else if (take1) begin
            out_status_nxt = tcfifo_pkg::ST_OK;
            out_ent_nxt    = 1'b1;
            out_cls_nxt    = 1'b1;
            out_id_nxt     = rdata1[ID_W-1:0];
            out_stamp_nxt  = rdata1[EW-1:ID_W];
            head1_nxt      = ring_inc(head1_r);
            cnt1_nxt       = cnt1_r - CNT_W'(1);
          end else begin
            out_status_nxt = tcfifo_pkg::ST_EMPTY;
            out_ent_nxt    = 1'b0;
            out_cls_nxt    = 1'b0;
            out_id_nxt     = '0;
            out_stamp_nxt  = '0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      head0_r   <= '0;
      head1_r   <= '0;
      cnt0_r    <= '0;
      cnt1_r    <= '0;
      stamp_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head0_r   <= head0_nxt;
      head1_r   <= head1_nxt;
      cnt0_r    <= cnt0_nxt;
      cnt1_r    <= cnt1_nxt;
      stamp_r   <= stamp_nxt;
      out_vld_r <= out_vld_nxt;
    end
    op_r         <= op_nxt;
    out_status_r <= out_status_nxt;
    out_ent_r    <= out_ent_nxt;
    out_cls_r    <= out_cls_nxt;
    out_id_r     <= out_id_nxt;
    out_stamp_r  <= out_stamp_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_cls_r;
  assign out_tdata  = {{(tcfifo_pkg::OUT_TDATA_W - 3 - ID_W - SW){1'b0}},
                       out_stamp_r, out_id_r, out_ent_r, out_status_r};

endmodule

// ----- rtl/core/tcfifo_checker.sv -----
// ----------------------------------------------------------------------------
// tcfifo_checker
// port-level checks of the two-class oldest-first queue unit
// ----------------------------------------------------------------------------
module tcfifo_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic [tcfifo_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [tcfifo_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                               out_tuser
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // dequeue blocks the input for its read cycle
  a_deq_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata[1:0] != tcfifo_pkg::OP_ENQ) |=> !in_tready)
    else $error("request taken during dequeue read");

  // a returned entry always has status ok
  a_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[1:0] == tcfifo_pkg::ST_OK)
    else $error("entry returned with bad status");

  // no entry means zero payload
  a_zero_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[2] |-> (out_tdata[50:3] == '0) && !out_tuser)
    else $error("nonzero payload without entry");

  // nothing is offered right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

endmodule

bind two_class_fifo_oldest_first_unit tcfifo_checker u_tcfifo_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
